// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on the rising edge, off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cdes_pkg.sv
// ----------------------------------------------------------------------------
// cdes_pkg
// Word types, pipeline stage types, constants and the month table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdes_pkg;

    localparam int unsigned EPOCH_YEAR   = 1970;
    localparam int unsigned EPOCH_DAYNUM = 719529;
    localparam int unsigned SECS_PER_DAY = 86400;
    localparam int unsigned SECS_PER_HR  = 3600;
    localparam int unsigned SECS_PER_MIN = 60;
    localparam int unsigned YEAR_DAYS    = 365;
    localparam int unsigned CENTURY      = 100;
    // floor(x / 25) == (x * RECIP25) >> RECIP_SHIFT for x < 4096
    localparam int unsigned RECIP25      = 5243;
    localparam int unsigned RECIP_SHIFT  = 17;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_in_word;

    typedef struct packed {
        logic [37:0] epoch_seconds;
        logic [21:0] epoch_days;
        logic        before_epoch;
    } t_out_word;

    // stage 1: products and partial day sum
    typedef struct packed {
        logic        pre;       // year before epoch
        logic [13:0] year;
        logic [23:0] base;      // year*365 + day + 1 + days before month
        logic        mgt2;      // month past February
        logic [11:0] pdiv4;     // (year-1)/4
        logic [24:0] prod_p;    // ((year-1)/4) * RECIP25
        logic [24:0] prod_y;    // (year/4) * RECIP25
        logic [16:0] tod_h;
        logic [11:0] tod_ms;
    } t_s1;

    // stage 2: signed day offset and time of day
    typedef struct packed {
        logic               pre;
        logic signed [23:0] d;
        logic [16:0]        tod;
    } t_s2;

    // stage 3: day offset scaled to seconds
    typedef struct packed {
        logic               pre;
        logic signed [40:0] prod;
        logic signed [23:0] days;
        logic [16:0]        tod;
    } t_s3;

    // stage 4: final values, untruncated
    typedef struct packed {
        logic        pre;
        logic [38:0] secs;
        logic [22:0] days;
    } t_s4;

    // cumulative days before month; month 0 as January, above 12 as December
    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] r;
        case (m) inside
            4'd0, 4'd1: r = 9'd0;
            4'd2:       r = 9'd31;
            4'd3:       r = 9'd59;
            4'd4:       r = 9'd90;
            4'd5:       r = 9'd120;
            4'd6:       r = 9'd151;
            4'd7:       r = 9'd181;
            4'd8:       r = 9'd212;
            4'd9:       r = 9'd243;
            4'd10:      r = 9'd273;
            4'd11:      r = 9'd304;
            default:    r = 9'd334;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/cdes_if.sv
// ----------------------------------------------------------------------------
// cdes_if
// Valid/ready channels for date words in and epoch words out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cdes_in_if;
    logic               valid;
    logic               ready;
    cdes_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cdes_out_if;
    logic                valid;
    logic                ready;
    cdes_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/calendar_date_to_epoch_seconds.sv
// ----------------------------------------------------------------------------
// calendar_date_to_epoch_seconds
// Gregorian date and time of day to Unix epoch seconds and whole days.
// ----------------------------------------------------------------------------
// Takes one date word per cycle while the input is ready and returns one
// epoch word per word taken, in order, through a four-stage register
// pipeline; with the sink ready a word enters and leaves in every cycle.
// Each stage holds its word only while the stage after it is full and
// stalled, so bubbles close up and the input keeps taking words while a
// result waits at the output. Years before 1970 give zero seconds and days
// with before_epoch set. Fields are not range checked: a day, hour, minute
// or second out of range simply adds its weight, month 0 counts as January
// and months above 12 as December. Far enough past year 9999 the outputs
// wrap to their widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module calendar_date_to_epoch_seconds (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cdes_in_if.sink    i_in,
    cdes_out_if.source o_out
);

    // Stage valid bits, and the per-stage load enables.
    // en[k] is high when stage k may take a new word; en[4] is the sink.
    logic [3:0] r_v;
    logic [4:0] en;

    cdes_pkg::t_s1 r_s1, n_s1;
    cdes_pkg::t_s2 r_s2, n_s2;
    cdes_pkg::t_s3 r_s3, n_s3;
    cdes_pkg::t_s4 r_s4, n_s4;

    always_comb begin
        en[4] = o_out.ready;
        for (int k = 3; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign i_in.ready = en[0];

    // ------------------------------------------------------------------
    // Stage 1: constant products, month table, partial sums.
    // Leap days of earlier years need (year-1)/100, done as
    // ((year-1)/4)/25 with a reciprocal multiply; same for year/100.
    // ------------------------------------------------------------------
    logic [13:0] ym1;
    logic [11:0] ym1_q4;
    logic [11:0] y_q4;

    always_comb begin
        ym1    = i_in.data.year - 14'd1;
        ym1_q4 = ym1[13:2];
        y_q4   = i_in.data.year[13:2];

        n_s1.pre    = (i_in.data.year < 14'(cdes_pkg::EPOCH_YEAR));
        n_s1.year   = i_in.data.year;
        n_s1.base   = 24'(i_in.data.year) * 24'(cdes_pkg::YEAR_DAYS)
                    + 24'(i_in.data.day) + 24'd1
                    + 24'(cdes_pkg::days_before_month(i_in.data.month));
        n_s1.mgt2   = (i_in.data.month > 4'd2);
        n_s1.pdiv4  = ym1_q4;
        n_s1.prod_p = 25'(ym1_q4) * 25'(cdes_pkg::RECIP25);
        n_s1.prod_y = 25'(y_q4) * 25'(cdes_pkg::RECIP25);
        n_s1.tod_h  = 17'(i_in.data.hour) * 17'(cdes_pkg::SECS_PER_HR);
        n_s1.tod_ms = 12'(i_in.data.minute) * 12'(cdes_pkg::SECS_PER_MIN)
                    + 12'(i_in.data.second);
    end

    // ------------------------------------------------------------------
    // Stage 2: century corrections, leap year test, day offset from epoch.
    // From 1970 on, the offset goes negative only for January day 0 of 1970, as -1.
    // ------------------------------------------------------------------
    logic [7:0]  q100p, q400p, q100y;
    logic        leap;
    logic [23:0] dsum;

    always_comb begin
        q100p = r_s1.prod_p[cdes_pkg::RECIP_SHIFT +: 8];
        q400p = {2'b00, q100p[7:2]};
        q100y = r_s1.prod_y[cdes_pkg::RECIP_SHIFT +: 8];
        // divisible by 4, and either not by 100 or also by 400
        leap  = (r_s1.year[1:0] == 2'b00)
             && ((15'(q100y) * 15'(cdes_pkg::CENTURY) != {1'b0, r_s1.year})
                 || (q100y[1:0] == 2'b00));
        dsum  = r_s1.base + 24'(leap && r_s1.mgt2) + 24'(r_s1.pdiv4)
              - 24'(q100p) + 24'(q400p) - 24'(cdes_pkg::EPOCH_DAYNUM);

        n_s2.pre = r_s1.pre;
        n_s2.d   = $signed(dsum);
        n_s2.tod = 17'(r_s1.tod_h) + 17'(r_s1.tod_ms);
    end

    // ------------------------------------------------------------------
    // Stage 3: scale days to seconds. The time of day stays below two
    // days, so the whole-day count gains at most one.
    // ------------------------------------------------------------------
    logic carry;

    always_comb begin
        carry     = (r_s2.tod >= 17'(cdes_pkg::SECS_PER_DAY));
        n_s3.pre  = r_s2.pre;
        n_s3.prod = 41'(r_s2.d) * 41'sd86400;
        n_s3.days = r_s2.d + $signed({23'd0, carry});
        n_s3.tod  = r_s2.tod;
    end

    // ------------------------------------------------------------------
    // Stage 4: add time of day; a negative total and pre-epoch years
    // clamp to zero.
    // ------------------------------------------------------------------
    logic [40:0] secs_sum;

    always_comb begin
        secs_sum = r_s3.prod + 41'(r_s3.tod);
        n_s4.pre = r_s3.pre;
        if (r_s3.pre || r_s3.days[23]) begin
            n_s4.secs = '0;
            n_s4.days = '0;
        end else begin
            n_s4.secs = secs_sum[38:0];
            n_s4.days = r_s3.days[22:0];
        end
    end

    // Valid bits: reset, and load from upstream whenever enabled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_in.valid;
            if (en[1]) r_v[1] <= r_v[0];
            if (en[2]) r_v[2] <= r_v[1];
            if (en[3]) r_v[3] <= r_v[2];
        end
    end

    // Payload: no reset.
    always_ff @(posedge i_clk) begin
        if (en[0]) r_s1 <= n_s1;
        if (en[1]) r_s2 <= n_s2;
        if (en[2]) r_s3 <= n_s3;
        if (en[3]) r_s4 <= n_s4;
    end

    assign o_out.valid              = r_v[3];
    assign o_out.data.epoch_seconds = r_s4.secs[37:0];
    assign o_out.data.epoch_days    = r_s4.days[21:0];
    assign o_out.data.before_epoch  = r_s4.pre;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Pre-epoch results carry zero fields.
    `ASSERT_IMPL(a_pre_zero, i_clk, i_rst_n, r_v[3] && r_s4.pre,
        (r_s4.secs == 39'd0) && (r_s4.days == 23'd0), "pre-epoch word not zero")

    // Days is the floor of seconds over one day.
    `ASSERT_IMPL(a_days_floor, i_clk, i_rst_n, r_v[3],
        ((40'(r_s4.days) * 40'd86400) <= 40'(r_s4.secs))
        && (40'(r_s4.secs) < (40'(r_s4.days) * 40'd86400 + 40'd86400)),
        "days and seconds disagree")

    // An empty output stage never blocks the input.
    `ASSERT_IMPL(a_no_block, i_clk, i_rst_n, !r_v[3], i_in.ready,
        "input stalled with empty output stage")

    // A stalled result is not dropped.
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_v[3] && !o_out.ready, r_v[3],
        "stalled result lost")

endmodule

// File: verif/tb_calendar_date_to_epoch_seconds.sv
// ----------------------------------------------------------------------------
// tb_calendar_date_to_epoch_seconds
// Self-checking bench for the date to epoch seconds converter.
// ----------------------------------------------------------------------------
// Date words go in over a valid/ready channel. A local calculation of
// seconds and whole days since 1970-01-01 runs for each word the block
// takes. A monitor compares each epoch word that leaves the block, field
// by field, with the oldest outstanding prediction.
// Stimulus runs in this order:
// - directed corners
// - well-formed dates under three output stall styles
// - raw bit patterns
// - a long output hold that backs up the pipeline
// - a gap-free full-rate stretch
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_calendar_date_to_epoch_seconds;

    localparam longint FIRST_YEAR  = 1970;
    localparam longint DAY0_NUMBER = 719529;    // day number of 1970-01-01
    localparam longint DAY_SECS    = 86400;
    localparam longint HOUR_SECS   = 3600;

    // output stall styles
    typedef enum {
        SINK_OPEN,      // always ready
        SINK_COIN,      // random per cycle
        SINK_COMB       // rotating fixed mask
    } t_sink_mode;

    logic i_clk;
    logic i_rst_n;

    cdes_in_if  date_ch ();
    cdes_out_if epoch_ch ();

    calendar_date_to_epoch_seconds DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (date_ch.sink),
        .o_out   (epoch_ch.source)
    );

    cdes_pkg::t_out_word due_epochs[$];     // predictions, oldest first
    int         mismatches  = 0;
    int         n_checked   = 0;
    int         n_pre_epoch = 0;
    int         n_clamped   = 0;
    int         n_wrapped   = 0;

    // source pacing
    bit         src_gaps_on = 1'b0;
    int         burst_left  = 0;

    // sink pacing; hold_request is picked up and counted down by the sink
    t_sink_mode sink_mode    = SINK_OPEN;
    int         hold_request = 0;
    int         hold_left    = 0;
    logic [15:0] sink_comb   = 16'b1110_0110_1011_0001;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Calendar arithmetic
    // ------------------------------------------------------------------
    function automatic bit leap_year(input longint yr);
        return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
    endfunction

    // days in the months ahead of month m (1..12)
    function automatic longint days_ahead(input longint m);
        case (m)
            1:       return 0;
            2:       return 31;
            3:       return 59;
            4:       return 90;
            5:       return 120;
            6:       return 151;
            7:       return 181;
            8:       return 212;
            9:       return 243;
            10:      return 273;
            11:      return 304;
            default: return 334;
        endcase
    endfunction

    // Epoch word for one date word. Month 0 adds nothing (same as January),
    // months past 12 count as December, other fields just add their weight.
    // A sum below zero clamps to zero; both fields wrap to their widths.
    function automatic cdes_pkg::t_out_word date_to_epoch(input cdes_pkg::t_in_word w);
        longint              yr, mo, dy, hr, mn, sc, total, prev, secs, days;
        cdes_pkg::t_out_word r;
        yr = w.year;
        mo = w.month;
        dy = w.day;
        hr = w.hour;
        mn = w.minute;
        sc = w.second;
        r  = '0;
        if (yr < FIRST_YEAR) begin
            r.before_epoch = 1'b1;
            return r;
        end
        if (mo > 12)
            mo = 12;
        total = yr * 365 + dy + 1;
        if (mo >= 1) begin
            total = total + days_ahead(mo);
            if (mo > 2 && leap_year(yr))
                total = total + 1;
        end
        prev  = yr - 1;
        total = total + prev / 4 - prev / 100 + prev / 400;
        secs  = (total - DAY0_NUMBER) * DAY_SECS + hr * HOUR_SECS + mn * 60 + sc;
        if (secs < 0)
            secs = 0;
        days = secs / DAY_SECS;
        r.epoch_seconds = secs[37:0];
        r.epoch_days    = days[21:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch report
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("%0t ns  mismatch %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Sink: ready pattern, plus a counted long hold on request
    // ------------------------------------------------------------------
    initial begin
        epoch_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                epoch_ch.ready <= 1'b0;
            end else begin
                case (sink_mode)
                    SINK_OPEN: begin
                        epoch_ch.ready <= 1'b1;
                    end
                    SINK_COIN: begin
                        epoch_ch.ready <= ($urandom_range(0, 99) < 65);
                    end
                    default: begin
                        epoch_ch.ready <= sink_comb[0];
                        sink_comb = {sink_comb[0], sink_comb[15:1]};
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every word taken at the output against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cdes_pkg::t_out_word got;
        cdes_pkg::t_out_word want;
        if (i_rst_n && epoch_ch.valid && epoch_ch.ready) begin
            got = epoch_ch.data;
            if (due_epochs.size() == 0) begin
                note_mismatch("unexpected word, seconds", got.epoch_seconds, 0);
            end else begin
                want = due_epochs.pop_front();
                n_checked++;
                if (want.before_epoch)
                    n_pre_epoch++;
                if (got.epoch_seconds !== want.epoch_seconds)
                    note_mismatch("epoch_seconds", got.epoch_seconds, want.epoch_seconds);
                if (got.epoch_days !== want.epoch_days)
                    note_mismatch("epoch_days", got.epoch_days, want.epoch_days);
                if (got.before_epoch !== want.before_epoch)
                    note_mismatch("before_epoch", got.before_epoch, want.before_epoch);
            end
        end
    end

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------
    // Offers one word from the current edge on and returns at the edge that
    // takes it; the prediction is queued right there.
    task automatic send_date(input cdes_pkg::t_in_word w);
        date_ch.valid <= 1'b1;
        date_ch.data  <= w;
        do @(posedge i_clk); while (date_ch.ready !== 1'b1);
        due_epochs.push_back(date_to_epoch(w));
        if (w.year > 9999)
            n_wrapped++;
        if (w.year == FIRST_YEAR && w.day == 0 && w.month <= 1)
            n_clamped++;
    endtask

    // Bursts of random length split by random gaps when gaps are on.
    task automatic send_fields(input int yr, input int mo, input int dy,
                               input int hr, input int mn, input int sc);
        cdes_pkg::t_in_word w;
        w.year   = yr[13:0];
        w.month  = mo[3:0];
        w.day    = dy[4:0];
        w.hour   = hr[4:0];
        w.minute = mn[5:0];
        w.second = sc[5:0];
        if (src_gaps_on) begin
            if (burst_left == 0) begin
                date_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        send_date(w);
    endtask

    // Stop offering and wait for every outstanding result.
    task automatic drain_results();
        date_ch.valid <= 1'b0;
        do @(posedge i_clk); while (due_epochs.size() != 0);
        burst_left = 0;
    endtask

    // A well-formed date: mostly near the epoch, some far out, a few before.
    task automatic send_calendar_date();
        int yr, mo, dy, mlen, pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            yr = $urandom_range(1970, 2100);
        else if (pick < 90)
            yr = $urandom_range(1970, 9999);
        else
            yr = $urandom_range(0, 1969);
        mo   = $urandom_range(1, 12);
        mlen = (mo == 12) ? 31 : int'(days_ahead(mo + 1) - days_ahead(mo));
        if (mo == 2 && leap_year(yr))
            mlen++;
        // lean on month ends
        dy = ($urandom_range(0, 3) == 0) ? mlen : $urandom_range(1, mlen);
        send_fields(yr, mo, dy, $urandom_range(0, 23), $urandom_range(0, 59),
                    $urandom_range(0, 59));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_corners();
        sink_mode   = SINK_COIN;
        src_gaps_on = 1'b1;
        send_fields(1970, 1, 1, 0, 0, 0);           // epoch itself
        send_fields(1969, 12, 31, 23, 59, 59);      // last second before epoch
        send_fields(0, 0, 0, 0, 0, 0);
        send_fields(1970, 1, 0, 23, 59, 59);        // day zero of 1970 clamps
        send_fields(1970, 1, 0, 0, 0, 0);
        send_fields(1970, 0, 1, 0, 0, 1);           // month zero as January
        send_fields(2024, 13, 1, 0, 0, 0);          // past twelve as December
        send_fields(2024, 15, 31, 12, 0, 0);
        send_fields(2000, 2, 29, 12, 34, 56);       // leap by 400 rule
        send_fields(2000, 3, 1, 0, 0, 0);
        send_fields(2100, 2, 28, 0, 0, 0);
        send_fields(2100, 3, 1, 0, 0, 0);           // century, not leap
        send_fields(2400, 3, 1, 0, 0, 0);
        send_fields(2023, 2, 31, 0, 0, 0);          // day runs into March
        send_fields(2038, 1, 19, 3, 14, 8);         // past 31-bit time
        send_fields(9999, 12, 31, 23, 59, 59);      // top of the nominal range
        send_fields(10000, 1, 1, 0, 0, 0);
        send_fields(16383, 15, 31, 31, 63, 63);     // all ones, wraps
        send_fields(1969, 15, 31, 31, 63, 63);
        send_fields(1970, 12, 31, 31, 63, 63);      // time of day over range
        send_fields(1972, 2, 29, 0, 0, 0);
        send_fields(8191, 8, 16, 16, 32, 32);
        send_fields(5461, 5, 10, 10, 21, 21);       // alternating bits
        send_fields(10922, 10, 21, 21, 42, 42);
        drain_results();
    endtask

    task automatic test_calendar_stream(input int count, input t_sink_mode mode,
                                        input bit gaps);
        sink_mode   = mode;
        src_gaps_on = gaps;
        repeat (count) send_calendar_date();
    endtask

    // Any bit pattern in every field.
    task automatic test_raw_fields(input int count);
        sink_mode   = SINK_COIN;
        src_gaps_on = 1'b1;
        repeat (count)
            send_fields($urandom_range(0, 16383), $urandom_range(0, 15),
                        $urandom_range(0, 31), $urandom_range(0, 31),
                        $urandom_range(0, 63), $urandom_range(0, 63));
    endtask

    // Output held off for a long stretch while the source keeps offering:
    // the pipe fills and the input must stall without losing a word.
    task automatic test_output_backpressure();
        sink_mode    = SINK_OPEN;
        src_gaps_on  = 1'b0;
        hold_request = 200;
        repeat (60) send_calendar_date();
        drain_results();
    endtask

    task automatic test_full_rate();
        sink_mode   = SINK_OPEN;
        src_gaps_on = 1'b0;
        repeat (200) send_calendar_date();
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       <= 1'b0;
        date_ch.valid <= 1'b0;
        date_ch.data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        test_calendar_stream(300, SINK_COIN, 1'b1);
        test_calendar_stream(300, SINK_COMB, 1'b1);
        test_calendar_stream(150, SINK_OPEN, 1'b1);
        test_calendar_stream(150, SINK_COIN, 1'b0);
        drain_results();
        test_raw_fields(300);
        drain_results();
        test_output_backpressure();
        test_full_rate();

        // pipeline is four deep; give stray words a chance to show up
        repeat (12) @(posedge i_clk);
        if (due_epochs.size() != 0)
            note_mismatch("results never delivered", due_epochs.size(), 0);

        $display("checked %0d epoch words: %0d before 1970, %0d clamped at zero,",
                 n_checked, n_pre_epoch, n_clamped);
        $display("%0d beyond year 9999; random, patterned and long output stalls",
                 n_wrapped);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", due_epochs.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/cdes_pkg.sv
rtl/cdes_if.sv
rtl/calendar_date_to_epoch_seconds.sv
verif/tb_calendar_date_to_epoch_seconds.sv
